// ===== hdl/afm_pkg.sv =====
// Package for the acquisition frame monitor: frame and result word types,
// register indexes, slot and excitation constants and the pattern decoders.
// No dependencies.
package afm_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_SEL   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_CYCLES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORDING_ON  = 2'd2;

  // Excitation pattern codes.
  localparam logic [2:0] PAT_ANY_COIL = 3'd0;
  localparam logic [2:0] PAT_COIL_1   = 3'd1;
  localparam logic [2:0] PAT_COIL_2   = 3'd2;
  localparam logic [2:0] PAT_COIL_3   = 3'd3;
  localparam logic [2:0] PAT_NEVER    = 3'd4;
  localparam logic [2:0] PAT_GROUP    = 3'd5;

  localparam logic [2:0] RESET_PATTERN = PAT_GROUP;
  localparam logic [7:0] RESET_CYCLES  = 8'd2;

  localparam logic [15:0] SLOT_MASK       = 16'h0038;
  localparam logic [15:0] SLOT_CODE       = 16'h0030;
  localparam logic [15:0] GO_COMPARE_MASK = 16'hbf00;
  localparam logic [7:0]  CYCLE_SCALE     = 8'd27;

  typedef struct packed {
    logic [15:0] seq_word;
    logic [15:0] excite_word;
    logic [15:0] odom_word;
  } frame_t;

  typedef struct packed {
    logic               seq_error;
    logic               trigger_seen;
    logic               record_boundary;
    logic               odom_valid;
    logic signed [31:0] odom_total_a;
    logic signed [31:0] odom_total_b;
    logic signed [31:0] odom_total_c;
    logic signed [31:0] odom_total_d;
    logic [7:0]         odom_flags;
  } result_t;

  // Status bits that arm the trigger for a pattern.
  function automatic logic [15:0] arm_bits(input logic [2:0] pat);
    logic [15:0] m;
    unique case (pat)
      PAT_ANY_COIL: m = 16'hbf00;
      PAT_COIL_1:   m = 16'h0100;
      PAT_COIL_2:   m = 16'h0400;
      PAT_COIL_3:   m = 16'h1000;
      PAT_GROUP:    m = 16'h3c00;
      default:      m = 16'h0000;
    endcase
    return m;
  endfunction

  // Masked status value that fires an armed trigger for a pattern.
  function automatic logic [15:0] go_pattern(input logic [2:0] pat);
    logic [15:0] g;
    unique case (pat)
      PAT_COIL_1: g = 16'h0200;
      PAT_COIL_2: g = 16'h0800;
      PAT_COIL_3: g = 16'h2000;
      PAT_GROUP:  g = 16'h0200;
      default:    g = 16'h0000;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/afm_stream_if.sv =====
// Valid/ready stream interface that carries one word of a given type.
// Used with afm_pkg::frame_t and afm_pkg::result_t.
interface afm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/acq_frame_monitor.sv =====
// Acquisition frame monitor top level: sequence check, odometer unwrap and
// trigger counting. Depends on afm_pkg and afm_stream_if.
//
// The monitor takes one acquisition frame word per clock on the frames
// stream and returns one result word per frame on the results stream, in the
// cycle after the frame is taken. All the work for a frame (sequence
// compare, odometer byte store, four parallel 32-bit unwrap adds, trigger
// match and record counter) sits between the accepted frame and a single
// result register, so the sustained rate is one frame per cycle. Frames
// stall only while the result register holds a word that the sink has not
// taken, and no frame is taken while reset is held. The first frame after
// reset seeds the expected sequence value.
// Frames whose sequence bits 5..3 equal 6 carry odometer byte seq[2:0];
// totals update on byte 7 when any byte of the slot cycle changed, and the
// totals and flags always show the last held values. Configuration writes
// take effect at once and are meant to happen while the block is idle.
module acq_frame_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [afm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [afm_pkg::CFG_DATA_W-1:0]  cfg_data,
  afm_stream_if.sink                    frames,
  afm_stream_if.source                  results
);
  import afm_pkg::*;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_OPEN,
    PHASE_CHANGED
  } phase_t;

  localparam logic signed [17:0] STEP_HALF = 18'sd32768;
  localparam logic signed [17:0] STEP_FULL = 18'sd65536;

  // Configuration registers.
  logic [2:0] pattern_sel;
  logic [7:0] record_cycles;
  logic       recording_on;

  // Monitor state.
  logic [15:0] expected_seq;
  logic        seq_seeded;
  logic [7:0]  odom_bytes [8];
  phase_t      odom_phase;
  logic        armed;
  logic [31:0] odom_acc [4];
  logic [7:0]  flags_hold;
  logic [15:0] cycles_done;

  // Result register.
  logic    res_valid;
  result_t res_word;

  // Next values.
  logic [15:0] expected_seq_next;
  logic [7:0]  odom_bytes_next [8];
  phase_t      odom_phase_next;
  logic        armed_next;
  logic [31:0] odom_acc_next [4];
  logic [7:0]  flags_hold_next;
  logic [15:0] cycles_done_next;
  result_t     res_word_next;

  logic        accept;
  logic [15:0] seq, exc, odo;
  logic [15:0] seq_ref;
  logic        seq_err;
  logic        is_slot;
  logic [2:0]  ix;
  logic [7:0]  byte_in;
  phase_t      phase_open;
  logic        byte_changed;
  logic        odom_update;
  logic [15:0] counter [4];
  logic signed [17:0] step_raw [4];
  logic signed [17:0] step [4];
  logic        trig;
  logic        boundary;
  logic [15:0] net_cycles;
  logic [15:0] cycles_inc;

  // A frame is taken whenever the result register is empty or drains now.
  assign frames.ready  = !rst && (!res_valid || results.ready);
  assign accept        = frames.valid && frames.ready;
  assign results.valid = res_valid;
  assign results.data  = res_word;

  assign seq     = frames.data.seq_word;
  assign exc     = frames.data.excite_word;
  assign odo     = frames.data.odom_word;
  assign is_slot = (seq & SLOT_MASK) == SLOT_CODE;
  assign ix      = seq[2:0];
  assign byte_in = odo[7:0];

  // Sequence check: an unseeded monitor compares against the frame itself.
  assign seq_ref           = seq_seeded ? expected_seq : seq;
  assign seq_err           = seq != seq_ref;
  assign expected_seq_next = seq + 16'd1;

  // Odometer slot cycle. Byte 0 opens a cycle; a byte is only stored while
  // a cycle is open and then marks the cycle as changed.
  always_comb begin
    phase_open      = (ix == 3'd0) ? PHASE_OPEN : odom_phase;
    byte_changed    = (phase_open != PHASE_IDLE) && (odom_bytes[ix] != byte_in);
    odom_update     = 1'b0;
    odom_phase_next = PHASE_IDLE;
    if (is_slot) begin
      odom_phase_next = byte_changed ? PHASE_CHANGED : phase_open;
      if (ix == 3'd7 && odom_phase_next == PHASE_CHANGED) begin
        odom_update     = 1'b1;
        odom_phase_next = PHASE_IDLE;
      end
    end
    for (int i = 0; i < 8; i++) begin
      odom_bytes_next[i] = (is_slot && byte_changed && ix == 3'(i)) ? byte_in
                                                                     : odom_bytes[i];
    end
  end

  // Unwrap: the step from the held low half to the new counter is folded
  // into -32768..+32768, keeping the raw sign at exactly half a turn.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      counter[k]  = {odom_bytes_next[2*k+1], odom_bytes_next[2*k]};
      step_raw[k] = $signed({2'b00, counter[k]}) - $signed({2'b00, odom_acc[k][15:0]});
      if (step_raw[k] > STEP_HALF) begin
        step[k] = step_raw[k] - STEP_FULL;
      end else if (step_raw[k] < -STEP_HALF) begin
        step[k] = step_raw[k] + STEP_FULL;
      end else begin
        step[k] = step_raw[k];
      end
      odom_acc_next[k] = odom_update ? odom_acc[k] + {{14{step[k][17]}}, step[k]}
                                     : odom_acc[k];
    end
    flags_hold_next = odom_update ? odo[15:8] : flags_hold;
  end

  // Trigger detection and record counting.
  always_comb begin
    trig       = armed && ((exc & GO_COMPARE_MASK) == go_pattern(pattern_sel));
    armed_next = (exc & arm_bits(pattern_sel)) != 16'd0;
    net_cycles = (pattern_sel == PAT_GROUP) ? {8'd0, record_cycles}
                                            : 16'({8'd0, record_cycles} * {8'd0, CYCLE_SCALE});
    cycles_inc       = cycles_done + 16'd1;
    boundary         = 1'b0;
    cycles_done_next = cycles_done;
    if (seq_err) begin
      cycles_done_next = 16'd0;
    end else if (trig) begin
      boundary         = !(recording_on && cycles_inc < net_cycles);
      cycles_done_next = boundary ? 16'd0 : cycles_inc;
    end
  end

  always_comb begin
    res_word_next.seq_error       = seq_err;
    res_word_next.trigger_seen    = trig;
    res_word_next.record_boundary = boundary;
    res_word_next.odom_valid      = odom_update;
    res_word_next.odom_total_a    = $signed(odom_acc_next[0]);
    res_word_next.odom_total_b    = $signed(odom_acc_next[1]);
    res_word_next.odom_total_c    = $signed(odom_acc_next[2]);
    res_word_next.odom_total_d    = $signed(odom_acc_next[3]);
    res_word_next.odom_flags      = flags_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_sel   <= RESET_PATTERN;
      record_cycles <= RESET_CYCLES;
      recording_on  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_SEL:   pattern_sel   <= cfg_data[2:0];
        CFG_RECORD_CYCLES: record_cycles <= cfg_data;
        CFG_RECORDING_ON:  recording_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= 16'd0;
      seq_seeded   <= 1'b0;
      odom_phase   <= PHASE_IDLE;
      armed        <= 1'b0;
      flags_hold   <= 8'd0;
      cycles_done  <= 16'd0;
      res_valid    <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        odom_bytes[i] <= 8'd0;
      end
      for (int k = 0; k < 4; k++) begin
        odom_acc[k] <= 32'd0;
      end
    end else begin
      if (accept) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        expected_seq <= expected_seq_next;
        seq_seeded   <= 1'b1;
        odom_phase   <= odom_phase_next;
        armed        <= armed_next;
        flags_hold   <= flags_hold_next;
        cycles_done  <= cycles_done_next;
        odom_bytes   <= odom_bytes_next;
        odom_acc     <= odom_acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_word <= res_word_next;
    end
  end

  // A boundary is only marked on a counted trigger.
  a_boundary_needs_trigger: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res_word.record_boundary || res_word.trigger_seen))
    else $error("record boundary without trigger");

  // A frame with a sequence error never closes a record.
  a_no_boundary_on_error: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_word.seq_error && res_word.record_boundary))
    else $error("record boundary on sequence error");

  // Every accepted frame leaves a result word in the register.
  a_result_follows_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted frame produced no result");

  // A frame outside the odometer slot closes any open slot cycle.
  a_non_slot_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_slot) |=> odom_phase == PHASE_IDLE)
    else $error("slot cycle left open by non-slot frame");

endmodule
